FILE: hw/rtl/mahr_pkg.sv
// ============================================================================
// mahr_pkg
// Shared types and constants of the moving average relay block.
// ============================================================================
package mahr_pkg;

    localparam int unsigned WINDOW_DEF = 50;
    localparam int unsigned SAMPLE_W   = 10;
    localparam int unsigned SUM_W      = 16;
    localparam int unsigned LEVEL_W    = 16;
    localparam int unsigned VOLT_W     = 4;
    localparam int unsigned FRAC_W     = 12;
    localparam int unsigned CFG_IDX_W  = 8;

    localparam logic [LEVEL_W-1:0] AUX_ON_RST  = LEVEL_W'(7782);
    localparam logic [LEVEL_W-1:0] AUX_OFF_RST = LEVEL_W'(7373);
    localparam logic [LEVEL_W-1:0] RUN_ON_RST  = LEVEL_W'(8396);
    localparam logic [LEVEL_W-1:0] RUN_OFF_RST = LEVEL_W'(7988);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUX_ON  = 8'd0,
        CFG_AUX_OFF = 8'd1,
        CFG_RUN_ON  = 8'd2,
        CFG_RUN_OFF = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                run_enable;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] drive_value;
        logic                aux_closed;
        logic                run_closed;
        logic [VOLT_W-1:0]   volts_whole;
        logic [VOLT_W-1:0]   volts_tenth;
    } out_item_t;

    // item after the window sum has been updated
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                run_enable;
        logic [SUM_W-1:0]    window_sum;
    } sum_item_t;

endpackage

FILE: hw/rtl/mahr_ram.sv
// ============================================================================
// mahr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module mahr_ram #(
    parameter int unsigned WIDTH  = 10,
    parameter int unsigned DEPTH  = 50,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/mahr_window.sv
// ============================================================================
// mahr_window
// Sample ring in RAM with per-entry valid flags and the running window sum.
// ============================================================================
module mahr_window
    import mahr_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_stall,
    input  in_item_t  sample_data,
    output logic      sum_valid,
    input  logic      sum_stall,
    output sum_item_t sum_item
);

    localparam int unsigned SLOT_W = $clog2(WINDOW);

    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [WINDOW-1:0]   filled_reg, filled_next;
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_filled_reg;
    in_item_t            s1_item_reg;
    logic                s2_valid_reg, s2_valid_next;
    sum_item_t           s2_item_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] ram_rd_data;
    logic [SAMPLE_W-1:0] oldest;
    logic                accept;
    logic                s2_load;
    logic                s1_adv;

    assign s2_load      = !s2_valid_reg || !sum_stall;
    assign s1_adv       = s1_valid_reg && s2_load;
    assign sample_stall = s1_valid_reg && !s2_load;
    assign accept       = sample_valid && !sample_stall;

    // oldest sample is read and replaced at the same slot in one transfer
    mahr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW),
        .ADDR_W(SLOT_W)
    ) u_ring (
        .clk    (clk),
        .wr_en  (accept),
        .wr_addr(slot_reg),
        .wr_data(sample_data.sample),
        .rd_en  (accept),
        .rd_addr(slot_reg),
        .rd_data(ram_rd_data)
    );

    // never-written entries count as zero
    assign oldest = s1_filled_reg ? ram_rd_data : '0;

    always_comb
    begin
        slot_next     = slot_reg;
        filled_next   = filled_reg;
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        sum_next      = sum_reg;
        if (accept)
        begin
            filled_next[slot_reg] = 1'b1;
            if (slot_reg == SLOT_W'(WINDOW - 1))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (s2_load)
        begin
            s2_valid_next = s1_valid_reg;
        end
        if (s1_adv)
        begin
            sum_next = sum_reg - SUM_W'(oldest) + SUM_W'(s1_item_reg.sample);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            filled_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            slot_reg     <= slot_next;
            filled_reg   <= filled_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg   <= sample_data;
            s1_filled_reg <= filled_reg[slot_reg];
        end
        if (s1_adv)
        begin
            s2_item_reg.sample     <= s1_item_reg.sample;
            s2_item_reg.run_enable <= s1_item_reg.run_enable;
            s2_item_reg.window_sum <= sum_next;
        end
    end

    assign sum_valid = s2_valid_reg;
    assign sum_item  = s2_item_reg;

endmodule

FILE: hw/rtl/mahr_relay.sv
// ============================================================================
// mahr_relay
// Level registers, hysteresis latches, volts display digits and result register.
// ============================================================================
module mahr_relay
    import mahr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_data,
    input  logic                 sum_valid,
    output logic                 sum_stall,
    input  sum_item_t            sum_item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output out_item_t            result_data
);

    logic [LEVEL_W-1:0] aux_on_reg, aux_on_next;
    logic [LEVEL_W-1:0] aux_off_reg, aux_off_next;
    logic [LEVEL_W-1:0] run_on_reg, run_on_next;
    logic [LEVEL_W-1:0] run_off_reg, run_off_next;
    logic               aux_reg, aux_next;
    logic               run_reg, run_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg, out_item_next;
    logic               load;
    logic               take;
    logic [FRAC_W-1:0]  frac;
    logic [FRAC_W+3:0]  frac_x10;

    function automatic logic hysteresis(
        input logic             held,
        input logic [SUM_W-1:0] sum,
        input logic [LEVEL_W-1:0] on_level,
        input logic [LEVEL_W-1:0] off_level
    );
        logic res;
        priority if (sum > on_level)
        begin
            res = 1'b1;
        end
        else if (sum < off_level)
        begin
            res = 1'b0;
        end
        else
        begin
            res = held;
        end
        return res;
    endfunction

    assign load      = !out_valid_reg || !result_stall;
    assign sum_stall = !load;
    assign take      = sum_valid && load;

    // tenths digit only depends on the fraction below one volt
    assign frac     = sum_item.window_sum[FRAC_W-1:0];
    assign frac_x10 = {frac, 3'b000} + {2'b00, frac, 1'b0};

    always_comb
    begin
        aux_on_next  = aux_on_reg;
        aux_off_next = aux_off_reg;
        run_on_next  = run_on_reg;
        run_off_next = run_off_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_AUX_ON:  aux_on_next  = cfg_data;
                CFG_AUX_OFF: aux_off_next = cfg_data;
                CFG_RUN_ON:  run_on_next  = cfg_data;
                CFG_RUN_OFF: run_off_next = cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        aux_next       = aux_reg;
        run_next       = run_reg;
        out_valid_next = load ? sum_valid : out_valid_reg;
        out_item_next  = out_item_reg;
        if (take)
        begin
            if (sum_item.run_enable)
            begin
                aux_next = hysteresis(aux_reg, sum_item.window_sum, aux_on_reg, aux_off_reg);
                run_next = hysteresis(run_reg, sum_item.window_sum, run_on_reg, run_off_reg);
                out_item_next.drive_value = sum_item.sample;
            end
            else
            begin
                aux_next = 1'b0;
                run_next = 1'b0;
                out_item_next.drive_value = '0;
            end
            out_item_next.aux_closed  = aux_next;
            out_item_next.run_closed  = run_next;
            out_item_next.volts_whole = sum_item.window_sum[SUM_W-1:FRAC_W];
            out_item_next.volts_tenth = frac_x10[FRAC_W+3:FRAC_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aux_on_reg    <= AUX_ON_RST;
            aux_off_reg   <= AUX_OFF_RST;
            run_on_reg    <= RUN_ON_RST;
            run_off_reg   <= RUN_OFF_RST;
            aux_reg       <= 1'b0;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            aux_on_reg    <= aux_on_next;
            aux_off_reg   <= aux_off_next;
            run_on_reg    <= run_on_next;
            run_off_reg   <= run_off_next;
            aux_reg       <= aux_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_item_reg;

endmodule

FILE: hw/rtl/moving_average_hysteresis_relays_top.sv
// ============================================================================
// moving_average_hysteresis_relays_top
// Moving average of a speed reference with two hysteresis relay outputs.
// ============================================================================
// One sample transfer can be taken every clock cycle while sample_stall is
// low. Each sample passes three registers (ring read stage, sum stage, result
// register) in that order, the first loaded at its transfer edge. Throughput
// is set by the ring RAM, which reads the oldest sample and writes the new
// one at the same slot in the cycle of the transfer; the running sum feeds
// back on its own register. A result stall holds the stages in place and
// reaches the sample input only once the ring read stage is also full.
// Per-entry valid flags make the ring read as zero after reset, so the block
// is ready right out of reset with no clearing pass. Level registers are
// written through the cfg port, which is always ready; write them only while
// no sample is in flight.
module moving_average_hysteresis_relays_top
    import mahr_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  in_item_t             sample_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output out_item_t            result_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_data
);

    localparam int unsigned SUM_MAX = WINDOW * ((2 ** SAMPLE_W) - 1);

    logic      sum_valid;
    logic      sum_stall;
    sum_item_t sum_item;

    assign cfg_ready = 1'b1;

    mahr_window #(
        .WINDOW(WINDOW)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample_data (sample_data),
        .sum_valid   (sum_valid),
        .sum_stall   (sum_stall),
        .sum_item    (sum_item)
    );

    mahr_relay u_relay (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sum_valid   (sum_valid),
        .sum_stall   (sum_stall),
        .sum_item    (sum_item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data (result_data)
    );

`ifndef SYNTHESIS
    // sum can never exceed a full window of maximum samples
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid |-> (sum_item.window_sum <= SUM_MAX))
        else $error("window sum out of range");

    // a disabled item forces drive and both relays off
    a_disabled_off: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid && !sum_stall && !sum_item.run_enable) |=>
        (result_valid && (result_data.drive_value == '0)
         && !result_data.aux_closed && !result_data.run_closed))
        else $error("disabled item did not clear outputs");

    // whole volts follow the sum of the transferred item
    a_volts_whole: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid && !sum_stall) |=>
        (result_data.volts_whole == $past(sum_item.window_sum[SUM_W-1:FRAC_W])))
        else $error("volts whole mismatch");

    // tenths digit is a decimal digit
    a_tenth_digit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.volts_tenth <= 4'd9))
        else $error("tenths digit out of range");
`endif

endmodule
